FILE: hdl/disk_head_scheduler_unit_defines.svh
// Assertion macros used by the disk head scheduler datapath.
`ifndef DISK_HEAD_SCHEDULER_UNIT_DEFINES_SVH
`define DISK_HEAD_SCHEDULER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DHS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("disk head scheduler check failed");
`define DHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("disk head scheduler check failed");
`else
`define DHS_ASSERT_NOW(label, clk, rst, ante, cons)
`define DHS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/dhs_pkg.sv
// Types and constants shared by the disk head scheduler modules.
package dhs_pkg;

   localparam int TOT_W = 22;
   localparam int CSR_IDX_W = 2;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_RUN = 1'b1;

   localparam logic POLICY_FCFS = 1'b0;
   localparam logic POLICY_SCAN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_CYLINDER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_START   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POLICY_MODE  = 2'd2;

   typedef enum logic [1:0] {
      PASS_COUNT,
      PASS_UP,
      PASS_DOWN
   } pass_kind_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_DROP,
      EMIT_HEAD,
      EMIT_FCFS,
      EMIT_BEST,
      EMIT_TURN
   } emit_sel_type;

   typedef struct packed {
      logic          add;
      logic          start_run;
      logic          pass_start;
      logic          pass_run;
      pass_kind_type pass_kind;
      logic          fcfs_next;
      logic          mark_best;
      logic          below_dec;
      emit_sel_type  emit_sel;
      logic          emit_last;
      logic          clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic policy_scan;
      logic out_free;
      logic pass_done;
      logic found;
      logic below_zero;
      logic below_one;
      logic fcfs_last;
   } ctrl_status_type;

endpackage

FILE: hdl/dhs_datapath.sv
// Datapath: configuration, request store, search passes, movement and result register.
`include "disk_head_scheduler_unit_defines.svh"

module dhs_datapath #(
   parameter int MAX_REQUESTS = 32,
   parameter int CYL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dhs_pkg::ctrl_cmd_type          cmd,
   output dhs_pkg::ctrl_status_type       status,
   input  logic [CYL_BITS-1:0]            req_cylinder,
   input  logic                           csr_we,
   input  logic [dhs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [CYL_BITS-1:0]            csr_wdata,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [CYL_BITS-1:0]            rsp_position,
   output logic [dhs_pkg::TOT_W-1:0]      rsp_total_movement,
   output logic                           rsp_is_turnaround,
   output logic                           rsp_status,
   output logic                           rsp_last
);
   import dhs_pkg::*;

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int DEPTH = 1 << IDX_W;
   localparam int SUM_W = ((CYL_BITS > TOT_W) ? CYL_BITS : TOT_W) + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);
   localparam logic [TOT_W-1:0] TOT_SAT = '1;
   localparam logic [CYL_BITS-1:0] MAX_CYL_RESET = CYL_BITS'(65535);

   function automatic logic [CYL_BITS-1:0] clamp(input logic [CYL_BITS-1:0] v,
                                                 input logic [CYL_BITS-1:0] m);
      return (v > m) ? m : v;
   endfunction

   logic [CYL_BITS-1:0] max_cyl_ff, head_start_ff;
   logic                policy_ff;

   logic [CYL_BITS-1:0] store_mem [DEPTH];
   logic [CYL_BITS-1:0] rdata_ff;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DEPTH-1:0]    served_ff, served_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [CYL_BITS-1:0] best_v_ff, best_v_in;
   logic [CNT_W-1:0]    below_ff, below_in;
   logic [CYL_BITS-1:0] head_ff, head_in;
   logic [CYL_BITS-1:0] pos_ff, pos_in;
   logic [TOT_W-1:0]    total_ff, total_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CYL_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic [TOT_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                rsp_turn_ff, rsp_turn_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [CYL_BITS-1:0] head_clamp, rd_v, step_v, step_dist;
   logic [SUM_W-1:0]    sum;
   logic [TOT_W-1:0]    total_sat;
   logic                issue, more, hit, moving, load, out_free;

   assign head_clamp = clamp(head_start_ff, max_cyl_ff);
   assign rd_v       = clamp(rdata_ff, max_cyl_ff);
   assign more       = addr_ff < count_ff;
   assign issue      = cmd.pass_run && more;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load       = cmd.emit_sel != EMIT_NONE;
   assign moving     = (cmd.emit_sel == EMIT_FCFS) || (cmd.emit_sel == EMIT_BEST) ||
                       (cmd.emit_sel == EMIT_TURN);

   // A candidate must be unserved, on the right side of the head, and strictly
   // better than the current best, so equal cylinders go in store order.
   always_comb begin
      hit = 1'b0;
      case (cmd.pass_kind)
         PASS_UP: begin
            hit = !served_ff[rd_idx_ff] && (rd_v >= head_ff) &&
                  (!found_ff || (rd_v < best_v_ff));
         end
         PASS_DOWN: begin
            hit = !served_ff[rd_idx_ff] && (rd_v < head_ff) &&
                  (!found_ff || (rd_v > best_v_ff));
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cmd.emit_sel)
         EMIT_FCFS: step_v = rd_v;
         EMIT_BEST: step_v = best_v_ff;
         EMIT_TURN: step_v = max_cyl_ff;
         default:   step_v = pos_ff;
      endcase
   end

   assign step_dist = (step_v >= pos_ff) ? (step_v - pos_ff) : (pos_ff - step_v);
   assign sum       = SUM_W'(total_ff) + SUM_W'(step_dist);
   assign total_sat = (sum > SUM_W'(TOT_SAT)) ? TOT_SAT : sum[TOT_W-1:0];

   always_comb begin
      count_in    = count_ff;
      served_in   = served_ff;
      addr_in     = addr_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = addr_ff[IDX_W-1:0];
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_v_in   = best_v_ff;
      below_in    = below_ff;
      head_in     = head_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;

      if (cmd.add) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start_run) begin
         head_in   = head_clamp;
         pos_in    = head_clamp;
         total_in  = '0;
         below_in  = '0;
         served_in = '0;
      end
      if (cmd.pass_start) begin
         addr_in  = '0;
         found_in = 1'b0;
      end else if (cmd.pass_run) begin
         rd_vld_in = issue;
         if (issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
         if (rd_vld_ff) begin
            if ((cmd.pass_kind == PASS_COUNT) && (rd_v < head_ff)) begin
               below_in = below_ff + CNT_W'(1);
            end
            if (hit) begin
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_v_in   = rd_v;
            end
         end
      end
      if (cmd.fcfs_next) begin
         addr_in = addr_ff + CNT_W'(1);
      end
      if (cmd.mark_best) begin
         served_in[best_idx_ff] = 1'b1;
      end
      if (cmd.below_dec) begin
         below_in = below_ff - CNT_W'(1);
      end
      if (moving) begin
         pos_in   = step_v;
         total_in = total_sat;
      end
      if (cmd.clear) begin
         count_in  = '0;
         served_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_turn_in   = rsp_turn_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_turn_in   = cmd.emit_sel == EMIT_TURN;
         rsp_status_in = cmd.emit_sel == EMIT_DROP;
         rsp_last_in   = cmd.emit_last;
         case (cmd.emit_sel)
            EMIT_DROP: begin
               rsp_pos_in   = '0;
               rsp_total_in = '0;
            end
            EMIT_HEAD: begin
               rsp_pos_in   = head_clamp;
               rsp_total_in = '0;
            end
            default: begin
               rsp_pos_in   = step_v;
               rsp_total_in = total_sat;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cyl_ff    <= MAX_CYL_RESET;
         head_start_ff <= '0;
         policy_ff     <= POLICY_FCFS;
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_CYLINDER: max_cyl_ff    <= csr_wdata;
            REG_HEAD_START:   head_start_ff <= csr_wdata;
            REG_POLICY_MODE:  policy_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         store_mem[count_ff[IDX_W-1:0]] <= req_cylinder;
      end
      rdata_ff <= store_mem[addr_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         served_ff    <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         below_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         served_ff    <= served_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         below_ff     <= below_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_v_ff     <= best_v_in;
      head_ff       <= head_in;
      pos_ff        <= pos_in;
      total_ff      <= total_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_turn_ff   <= rsp_turn_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign status.full        = count_ff == MAX_CNT;
   assign status.empty       = count_ff == '0;
   assign status.policy_scan = policy_ff == POLICY_SCAN;
   assign status.out_free    = out_free;
   assign status.pass_done   = !more && !rd_vld_ff;
   assign status.found       = found_ff;
   assign status.below_zero  = below_ff == '0;
   assign status.below_one   = below_ff == CNT_W'(1);
   assign status.fcfs_last   = (addr_ff + CNT_W'(1)) == count_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_total_movement = rsp_total_ff;
   assign rsp_is_turnaround  = rsp_turn_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

   `DHS_ASSERT_NOW(a_load_into_free_slot, clock, reset, load, out_free)
   `DHS_ASSERT_NOW(a_drop_only_when_full, clock, reset, cmd.emit_sel == EMIT_DROP, status.full)
   `DHS_ASSERT_NEXT(a_run_end_empties_store, clock, reset, cmd.clear, count_ff == '0)
   `DHS_ASSERT_NOW(a_mark_needs_candidate, clock, reset, cmd.mark_best, found_ff)

endmodule

FILE: hdl/dhs_controller.sv
// Controller: sequences request intake, FCFS walks and SCAN search passes.
module dhs_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_cmd,
   output logic                     req_ready,
   input  dhs_pkg::ctrl_status_type status,
   output dhs_pkg::ctrl_cmd_type    cmd
);
   import dhs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FCFS_RD,
      ST_FCFS_EMIT,
      ST_CNT_PASS,
      ST_UP_PASS,
      ST_UP_EMIT,
      ST_TURN_EMIT,
      ST_DN_PASS,
      ST_DN_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_ADD) begin
                  if (status.full) begin
                     cmd.emit_sel  = EMIT_DROP;
                     cmd.emit_last = 1'b1;
                  end else begin
                     cmd.add = 1'b1;
                  end
               end else begin
                  cmd.start_run  = 1'b1;
                  cmd.pass_start = 1'b1;
                  if (status.policy_scan) begin
                     state_in = ST_CNT_PASS;
                  end else if (status.empty) begin
                     cmd.emit_sel  = EMIT_HEAD;
                     cmd.emit_last = 1'b1;
                     cmd.clear     = 1'b1;
                  end else begin
                     state_in = ST_FCFS_RD;
                  end
               end
            end
         end
         ST_FCFS_RD: begin
            state_in = ST_FCFS_EMIT;
         end
         ST_FCFS_EMIT: begin
            if (status.out_free) begin
               cmd.emit_sel  = EMIT_FCFS;
               cmd.emit_last = status.fcfs_last;
               cmd.fcfs_next = 1'b1;
               if (status.fcfs_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_FCFS_RD;
               end
            end
         end
         ST_CNT_PASS: begin
            cmd.pass_kind = PASS_COUNT;
            if (status.pass_done) begin
               cmd.pass_start = 1'b1;
               state_in       = ST_UP_PASS;
            end else begin
               cmd.pass_run = 1'b1;
            end
         end
         ST_UP_PASS: begin
            cmd.pass_kind = PASS_UP;
            if (status.pass_done) begin
               state_in = ST_UP_EMIT;
            end else begin
               cmd.pass_run = 1'b1;
            end
         end
         ST_UP_EMIT: begin
            if (!status.found) begin
               state_in = ST_TURN_EMIT;
            end else if (status.out_free) begin
               cmd.emit_sel   = EMIT_BEST;
               cmd.mark_best  = 1'b1;
               cmd.pass_start = 1'b1;
               state_in       = ST_UP_PASS;
            end
         end
         ST_TURN_EMIT: begin
            if (status.out_free) begin
               cmd.emit_sel  = EMIT_TURN;
               cmd.emit_last = status.below_zero;
               if (status.below_zero) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.pass_start = 1'b1;
                  state_in       = ST_DN_PASS;
               end
            end
         end
         ST_DN_PASS: begin
            cmd.pass_kind = PASS_DOWN;
            if (status.pass_done) begin
               state_in = ST_DN_EMIT;
            end else begin
               cmd.pass_run = 1'b1;
            end
         end
         ST_DN_EMIT: begin
            if (status.out_free) begin
               cmd.emit_sel  = EMIT_BEST;
               cmd.emit_last = status.below_one;
               cmd.mark_best = 1'b1;
               cmd.below_dec = 1'b1;
               if (status.below_one) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.pass_start = 1'b1;
                  state_in       = ST_DN_PASS;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/disk_head_scheduler_unit.sv
// Add request: no result, but when the store is full a drop report is ready the cycle after it is taken.
// FCFS run: each result takes a read state and an emit state, for the registered read of the request store.
// SCAN run: a counting pass, then per result one search pass and one emit step
// over the n stored requests, with a turnaround result at the maximum cylinder.
// Synchronous active-high reset clears the count, the served marks and the result valid flag;
// the stored cylinders are left as they are and no clearing pass is needed.
module disk_head_scheduler_unit #(
   parameter int MAX_REQUESTS = 32,
   parameter int CYL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [CYL_BITS-1:0]            req_cylinder,
   input  logic                           csr_we,
   input  logic [dhs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [CYL_BITS-1:0]            csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [CYL_BITS-1:0]            rsp_position,
   output logic [dhs_pkg::TOT_W-1:0]      rsp_total_movement,
   output logic                           rsp_is_turnaround,
   output logic                           rsp_status,
   output logic                           rsp_last
);
   import dhs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   dhs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dhs_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .CYL_BITS     (CYL_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_cylinder       (req_cylinder),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_position       (rsp_position),
      .rsp_total_movement (rsp_total_movement),
      .rsp_is_turnaround  (rsp_is_turnaround),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

endmodule

FILE: tb/disk_head_scheduler_unit_test.sv
// Self-checking testbench for the disk head scheduler: random requests, stalls and checks.
module disk_head_scheduler_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dhs_pkg::*;

   localparam int CYL_W = 16;
   localparam int QUEUE_DEPTH = 32;
   localparam int unsigned TOT_CAP = (1 << TOT_W) - 1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int END_CYCLES = 50;
   localparam int PHASE_ITEMS = 15;

   typedef struct {
      logic             cmd;
      logic [CYL_W-1:0] cylinder;
   } disk_request_type;

   typedef struct {
      logic [CYL_W-1:0] position;
      logic [TOT_W-1:0] movement;
      logic             turn;
      logic             dropped;
      logic             fin;
   } head_stop_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = CMD_ADD;
   logic [CYL_W-1:0]     req_cylinder = '0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_MAX_CYLINDER;
   logic [CYL_W-1:0]     csr_wdata = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CYL_W-1:0]     rsp_position;
   logic [TOT_W-1:0]     rsp_total_movement;
   logic                 rsp_is_turnaround;
   logic                 rsp_status;
   logic                 rsp_last;

   disk_head_scheduler_unit #(
      .MAX_REQUESTS(QUEUE_DEPTH),
      .CYL_BITS(CYL_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_cylinder(req_cylinder),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_position(rsp_position),
      .rsp_total_movement(rsp_total_movement),
      .rsp_is_turnaround(rsp_is_turnaround),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   initial forever #2 clock = ~clock;

   disk_request_type request_backlog[$];
   head_stop_type    stops_due[$];

   // Mirror of the scheduler state and its registers.
   int unsigned held_cyl [QUEUE_DEPTH];
   int unsigned held_n = 0;
   int unsigned head_at = 0;
   int unsigned travel = 0;
   int unsigned max_cyl = 65535;
   int unsigned head_reg = 0;
   logic        policy = POLICY_FCFS;

   int unsigned faults = 0;
   int unsigned stops_seen = 0;
   int unsigned issued = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit          hold_wanted = 0;
   bit          calm = 0;
   bit          req_taken = 0;

   task automatic report_fault(string msg);
      faults++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic void note_stop(int unsigned pos, logic turn, logic dropped, logic fin);
      head_stop_type s;
      s.position = pos[CYL_W-1:0];
      s.movement = travel[TOT_W-1:0];
      s.turn = turn;
      s.dropped = dropped;
      s.fin = fin;
      stops_due.push_back(s);
   endfunction

   function automatic void move_head(int unsigned pos);
      travel += (pos >= head_at) ? pos - head_at : head_at - pos;
      if (travel > TOT_CAP)
         travel = TOT_CAP;
      head_at = pos;
   endfunction

   function automatic void plan_head_stops(logic cmd, logic [CYL_W-1:0] cyl);
      int unsigned c [QUEUE_DEPTH];
      bit          done [QUEUE_DEPTH];
      int unsigned head;
      int unsigned below;
      int unsigned best;
      int unsigned i;
      int unsigned step;
      bit          found;
      if (cmd == CMD_ADD) begin
         if (held_n >= QUEUE_DEPTH) begin
            travel = 0;
            note_stop(0, 1'b0, 1'b1, 1'b1);
         end else begin
            held_cyl[held_n] = 32'(cyl);
            held_n++;
         end
         return;
      end
      head = (head_reg > max_cyl) ? max_cyl : head_reg;
      head_at = head;
      travel = 0;
      below = 0;
      best = 0;
      for (i = 0; i < held_n; i++) begin
         c[i] = (held_cyl[i] > max_cyl) ? max_cyl : held_cyl[i];
         done[i] = 0;
         if (c[i] < head)
            below++;
      end
      if (policy == POLICY_FCFS) begin
         if (held_n == 0)
            note_stop(head, 1'b0, 1'b0, 1'b1);
         for (i = 0; i < held_n; i++) begin
            move_head(c[i]);
            note_stop(c[i], 1'b0, 1'b0, i + 1 == held_n);
         end
      end else begin
         // Upward sweep takes the lowest unserved cylinder, the earliest one on a tie.
         for (step = 0; step < held_n - below; step++) begin
            found = 0;
            for (i = 0; i < held_n; i++)
               if (!done[i] && c[i] >= head && (!found || c[i] < c[best])) begin
                  best = i;
                  found = 1;
               end
            done[best] = 1;
            move_head(c[best]);
            note_stop(c[best], 1'b0, 1'b0, 1'b0);
         end
         move_head(max_cyl);
         note_stop(max_cyl, 1'b1, 1'b0, below == 0);
         for (step = 0; step < below; step++) begin
            found = 0;
            for (i = 0; i < held_n; i++)
               if (!done[i] && c[i] < head && (!found || c[i] > c[best])) begin
                  best = i;
                  found = 1;
               end
            done[best] = 1;
            move_head(c[best]);
            note_stop(c[best], 1'b0, 1'b0, step + 1 == below);
         end
      end
      held_n = 0;
   endfunction

   task automatic check_stop();
      head_stop_type want;
      stops_seen++;
      if (stops_due.size() == 0) begin
         report_fault($sformatf("result %0d arrived with nothing outstanding (position %0d)",
                                stops_seen, rsp_position));
         return;
      end
      want = stops_due.pop_front();
      if (rsp_position !== want.position)
         report_fault($sformatf("result %0d position %0d, expected %0d",
                                stops_seen, rsp_position, want.position));
      if (rsp_total_movement !== want.movement)
         report_fault($sformatf("result %0d total_movement %0d, expected %0d",
                                stops_seen, rsp_total_movement, want.movement));
      if (rsp_is_turnaround !== want.turn)
         report_fault($sformatf("result %0d is_turnaround %b, expected %b",
                                stops_seen, rsp_is_turnaround, want.turn));
      if (rsp_status !== want.dropped)
         report_fault($sformatf("result %0d status %b, expected %b",
                                stops_seen, rsp_status, want.dropped));
      if (rsp_last !== want.fin)
         report_fault($sformatf("result %0d last %b, expected %b",
                                stops_seen, rsp_last, want.fin));
   endtask

   // Monitor and watchdog.
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken)
            plan_head_stops(req_cmd, req_cylinder);
         if (rsp_valid && rsp_ready)
            check_stop();
         if (req_taken || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Request driver.
   always @(negedge clock) begin : drive_requests
      disk_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            next_req = request_backlog.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_req.cmd;
            req_cylinder <= next_req.cylinder;
            if (!calm && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver, with short stalls and the occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_wanted) begin
         hold_wanted = 0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 17);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CYL_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_MAX_CYLINDER: max_cyl = 32'(value);
         REG_HEAD_START:   head_reg = 32'(value);
         REG_POLICY_MODE:  policy = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup_phase(int unsigned m, int unsigned h, logic scan);
      logic [CYL_W-1:0] mode_word;
      mode_word = CYL_W'($urandom());
      mode_word[0] = scan;
      write_reg(REG_SPARE, CYL_W'($urandom()));
      write_reg(REG_MAX_CYLINDER, m[CYL_W-1:0]);
      write_reg(REG_HEAD_START, h[CYL_W-1:0]);
      write_reg(REG_POLICY_MODE, mode_word);
   endtask

   task automatic enqueue(logic cmd, logic [CYL_W-1:0] cyl);
      disk_request_type r;
      r.cmd = cmd;
      r.cylinder = cyl;
      request_backlog.push_back(r);
      issued++;
   endtask

   // Waits until every request is in and every result is out, then lets the block settle.
   task automatic drain();
      do @(posedge clock);
      while (request_backlog.size() != 0 || req_valid || stops_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_setup();
      int unsigned m;
      int unsigned h;
      case ($urandom_range(0, 3))
         0: m = 0;
         1: m = 65535;
         2: m = $urandom_range(0, 300);
         default: m = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 3))
         0: h = 0;
         1: h = 65535;
         2: h = $urandom_range(0, m);
         default: h = $urandom_range(0, 65535);
      endcase
      setup_phase(m, h, 1'($urandom_range(0, 1)));
   endtask

   // A batch of adds closed by a run; now and then the run is left out or doubled.
   task automatic queue_batch();
      int unsigned n;
      int unsigned k;
      logic [CYL_W-1:0] v;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 10);
      v = CYL_W'($urandom());
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = max_cyl[CYL_W-1:0];
            3: v = CYL_W'(max_cyl + 1);
            4: v = head_reg[CYL_W-1:0];
            5: ;
            default: v = CYL_W'($urandom());
         endcase
         enqueue(CMD_ADD, v);
      end
      if ($urandom_range(0, 7) != 0)
         enqueue(CMD_RUN, CYL_W'($urandom()));
      if ($urandom_range(0, 9) == 0)
         enqueue(CMD_RUN, CYL_W'($urandom()));
   endtask

   initial begin
      int unsigned p;
      int unsigned phase_start;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty runs, extremes, clamping, ties and a sweep with nothing below.
      setup_phase(65535, 0, POLICY_FCFS);
      enqueue(CMD_RUN, '0);
      enqueue(CMD_ADD, 16'd0);
      enqueue(CMD_ADD, 16'hFFFF);
      enqueue(CMD_ADD, 16'd12345);
      enqueue(CMD_ADD, 16'd12345);
      enqueue(CMD_RUN, '1);
      drain();
      setup_phase(1000, 65535, POLICY_SCAN);
      enqueue(CMD_RUN, '0);
      enqueue(CMD_ADD, 16'd1500);
      enqueue(CMD_ADD, 16'd1000);
      enqueue(CMD_ADD, 16'd300);
      enqueue(CMD_ADD, 16'd300);
      enqueue(CMD_ADD, 16'd0);
      enqueue(CMD_ADD, 16'd999);
      enqueue(CMD_RUN, '0);
      drain();
      setup_phase(40000, 100, POLICY_SCAN);
      enqueue(CMD_ADD, 16'd100);
      enqueue(CMD_ADD, 16'hFFFF);
      enqueue(CMD_ADD, 16'd200);
      enqueue(CMD_RUN, '0);
      drain();
      setup_phase(0, 0, POLICY_FCFS);
      enqueue(CMD_ADD, 16'd7);
      enqueue(CMD_ADD, 16'd0);
      enqueue(CMD_RUN, '0);
      drain();

      for (p = 0; p < 8; p++) begin
         random_setup();
         // In the second phase the receiver stops for a long while so the block backs up.
         if (p == 1)
            hold_wanted = 1;
         if (p == 7)
            calm = 1;
         phase_start = issued;
         while (issued - phase_start < PHASE_ITEMS)
            queue_batch();
         drain();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (stops_due.size() != 0)
         report_fault($sformatf("%0d results never arrived", stops_due.size()));
      if (faults == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
